>>> rtl/mprm_pkg.sv
// Shared types and constants for the PHY management register model.
// No dependencies; compile first.
package mprm_pkg;

	typedef enum logic [1:0] {
		FUNC_READ  = 2'd0,
		FUNC_WRITE = 2'd1,
		FUNC_LINK  = 2'd2
	} func_t;

	localparam logic [7:0] OFF_CTRL = 8'h60;
	localparam logic [7:0] OFF_DATA = 8'h64;

	localparam int CMD_WRITE_BIT = 27;
	localparam int CMD_READ_BIT  = 26;
	localparam int CMD_REG_LO    = 21;

	localparam logic [4:0] PHY_BMCR    = 5'd0;
	localparam logic [4:0] PHY_BMSR    = 5'd1;
	localparam logic [4:0] PHY_ID1     = 5'd2;
	localparam logic [4:0] PHY_ID2     = 5'd3;
	localparam logic [4:0] PHY_ADVERT  = 5'd4;
	localparam logic [4:0] PHY_LPA     = 5'd5;
	localparam logic [4:0] PHY_EXPAN   = 5'd6;
	localparam logic [4:0] PHY_IRQ_SRC = 5'd29;
	localparam logic [4:0] PHY_IRQ_EN  = 5'd30;

	localparam logic [15:0] STATUS_SRST   = 16'h7809;
	localparam logic [15:0] CONTROL_RST   = 16'h3000;
	localparam logic [15:0] ADVERT_RST    = 16'h01e1;
	localparam logic [15:0] STATUS_LINK   = 16'h0024;
	localparam logic [15:0] STATUS_ANEG   = 16'h0020;
	localparam logic [15:0] ID1_VALUE     = 16'h0007;
	localparam logic [15:0] ID2_VALUE     = 16'hc0d1;
	localparam logic [15:0] LPA_VALUE     = 16'h0f71;
	localparam logic [15:0] EXPAN_VALUE   = 16'h0001;
	localparam logic [15:0] CONTROL_MASK  = 16'h7980;
	localparam logic [15:0] ADVERT_MASK   = 16'h2d7f;
	localparam logic [15:0] ADVERT_FORCE  = 16'h0080;
	localparam logic [7:0]  IRQ_LINK_UP   = 8'hc0;
	localparam logic [7:0]  IRQ_LINK_LOST = 8'h10;
	localparam int          CTRL_RESET_BIT = 15;
	localparam int          CTRL_ANEG_BIT  = 12;

	// request from the management registers to the PHY model
	typedef struct packed {
		logic        wr;
		logic        rd;
		logic [4:0]  regnum;
		logic [15:0] wdata;
		logic        link_ev;
		logic        link_lost;
	} phy_req_t;

endpackage

>>> rtl/mprm_if.sv
// Valid/ready channel interfaces for bus and link items and their results.
// Depends on mprm_pkg.
interface mprm_req_if;
	logic                valid;
	logic                ready;
	mprm_pkg::func_t     func;
	logic [7:0]          bus_offset;
	logic [31:0]         write_data;
	logic                link_is_down;

	modport source (output valid, func, bus_offset, write_data, link_is_down, input ready);
	modport sink   (input valid, func, bus_offset, write_data, link_is_down, output ready);
endinterface

interface mprm_rsp_if;
	logic        valid;
	logic        ready;
	logic [31:0] read_data;

	modport source (output valid, read_data, input ready);
	modport sink   (input valid, read_data, output ready);
endinterface

>>> rtl/mdio_phy_register_model_unit.sv
// Top level of the PHY management register model: bus decode, model PHY
// and the result register. Depends on mprm_pkg, mprm_if, mprm_bus, mprm_phy.
//
// One item (bus read, bus write or link event) is taken per clock cycle and
// its result appears in the result register on the next cycle; a result
// that waits does not stop the next item as long as the sink takes it in
// the same cycle. All register updates happen in the cycle the item is
// taken. Every item gives exactly one result: the register value for bus
// reads at offset 0x60 or 0x64, zero for everything else.
module mdio_phy_register_model_unit (
	input  logic       clk,
	input  logic       arst_n,
	mprm_req_if.sink   req,
	mprm_rsp_if.source rsp
);
	import mprm_pkg::*;

	logic        accept;
	logic [15:0] phy_rdata;
	phy_req_t    phy_req;
	logic [31:0] rd_value;
	logic        valid_q;
	logic [31:0] read_data_q;

	assign req.ready = !valid_q || rsp.ready;
	assign accept    = req.valid && req.ready;

	mprm_bus u_bus (
		.clk          (clk),
		.arst_n       (arst_n),
		.en           (accept),
		.func         (req.func),
		.bus_offset   (req.bus_offset),
		.write_data   (req.write_data),
		.link_is_down (req.link_is_down),
		.phy_rdata    (phy_rdata),
		.phy_req      (phy_req),
		.rd_value     (rd_value)
	);

	mprm_phy u_phy (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (accept),
		.req    (phy_req),
		.rdata  (phy_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (req.ready) begin
			valid_q <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			read_data_q <= rd_value;
		end
	end

	assign rsp.valid     = valid_q;
	assign rsp.read_data = read_data_q;

endmodule

>>> rtl/mprm_phy.sv
// Model PHY register file: control, status, advertisement, interrupt regs.
// Depends on mprm_pkg.
module mprm_phy (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  mprm_pkg::phy_req_t req,
	output logic [15:0]        rdata
);
	import mprm_pkg::*;

	logic [15:0] control_q, status_q, advert_q;
	logic [7:0]  irq_src_q, irq_en_q;
	logic        link_lost_q;

	logic [15:0] control_d, status_d, advert_d;
	logic [7:0]  irq_src_d, irq_en_d;
	logic        link_lost_d;

	always_comb begin
		unique case (req.regnum)
			PHY_BMCR:    rdata = control_q;
			PHY_BMSR:    rdata = status_q;
			PHY_ID1:     rdata = ID1_VALUE;
			PHY_ID2:     rdata = ID2_VALUE;
			PHY_ADVERT:  rdata = advert_q;
			PHY_LPA:     rdata = LPA_VALUE;
			PHY_EXPAN:   rdata = EXPAN_VALUE;
			PHY_IRQ_SRC: rdata = {8'h00, irq_src_q};
			PHY_IRQ_EN:  rdata = {8'h00, irq_en_q};
			default:     rdata = 16'h0000;
		endcase
	end

	always_comb begin
		control_d   = control_q;
		status_d    = status_q;
		advert_d    = advert_q;
		irq_src_d   = irq_src_q;
		irq_en_d    = irq_en_q;
		link_lost_d = link_lost_q;
		if (req.link_ev) begin
			link_lost_d = req.link_lost;
			if (req.link_lost) begin
				status_d  = status_q & ~STATUS_LINK;
				irq_src_d = irq_src_q | IRQ_LINK_LOST;
			end else begin
				status_d  = status_q | STATUS_LINK;
				irq_src_d = irq_src_q | IRQ_LINK_UP;
			end
		end
		if (req.rd && req.regnum == PHY_IRQ_SRC) begin
			irq_src_d = 8'h00;
		end
		if (req.wr) begin
			unique case (req.regnum)
				PHY_BMCR: begin
					if (req.wdata[CTRL_RESET_BIT]) begin
						control_d = CONTROL_RST;
						advert_d  = ADVERT_RST;
						irq_en_d  = 8'h00;
						if (link_lost_q) begin
							status_d  = STATUS_SRST & ~STATUS_LINK;
							irq_src_d = IRQ_LINK_LOST;
						end else begin
							status_d  = STATUS_SRST | STATUS_LINK;
							irq_src_d = IRQ_LINK_UP;
						end
					end else begin
						control_d = req.wdata & CONTROL_MASK;
						if (req.wdata[CTRL_ANEG_BIT]) begin
							status_d = status_q | STATUS_ANEG;
						end
					end
				end
				PHY_ADVERT: advert_d = (req.wdata & ADVERT_MASK) | ADVERT_FORCE;
				PHY_IRQ_EN: irq_en_d = req.wdata[7:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			control_q   <= CONTROL_RST;
			status_q    <= STATUS_SRST | STATUS_LINK;
			advert_q    <= ADVERT_RST;
			irq_src_q   <= IRQ_LINK_UP;
			irq_en_q    <= 8'h00;
			link_lost_q <= 1'b0;
		end else if (en) begin
			control_q   <= control_d;
			status_q    <= status_d;
			advert_q    <= advert_d;
			irq_src_q   <= irq_src_d;
			irq_en_q    <= irq_en_d;
			link_lost_q <= link_lost_d;
		end
	end

endmodule

>>> rtl/mprm_bus.sv
// MAC-side management command and data words, bus decode and PHY request.
// Depends on mprm_pkg.
module mprm_bus (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  mprm_pkg::func_t    func,
	input  logic [7:0]         bus_offset,
	input  logic [31:0]        write_data,
	input  logic               link_is_down,
	input  logic [15:0]        phy_rdata,
	output mprm_pkg::phy_req_t phy_req,
	output logic [31:0]        rd_value
);
	import mprm_pkg::*;

	logic [31:0] command_q, data_q;
	logic [31:0] command_d, data_d;
	logic        ctrl_wr;

	assign ctrl_wr = (func == FUNC_WRITE) && (bus_offset == OFF_CTRL);

	always_comb begin
		phy_req.wr        = ctrl_wr && write_data[CMD_WRITE_BIT];
		phy_req.rd        = ctrl_wr && !write_data[CMD_WRITE_BIT];
		phy_req.regnum    = write_data[CMD_REG_LO +: 5];
		phy_req.wdata     = data_q[15:0];
		phy_req.link_ev   = (func == FUNC_LINK);
		phy_req.link_lost = link_is_down;
	end

	always_comb begin
		rd_value = 32'h0;
		if (func == FUNC_READ) begin
			if (bus_offset == OFF_CTRL) begin
				rd_value = command_q;
			end else if (bus_offset == OFF_DATA) begin
				rd_value = data_q;
			end
		end
	end

	always_comb begin
		command_d = command_q;
		data_d    = data_q;
		if (ctrl_wr) begin
			command_d = write_data;
			if (write_data[CMD_WRITE_BIT]) begin
				command_d[CMD_WRITE_BIT] = 1'b0;
			end else begin
				command_d[CMD_READ_BIT] = 1'b0;
				data_d = {phy_rdata, 16'h0000};
			end
		end else if (func == FUNC_WRITE && bus_offset == OFF_DATA) begin
			data_d = write_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			command_q <= 32'h0;
			data_q    <= 32'h0;
		end else if (en) begin
			command_q <= command_d;
			data_q    <= data_d;
		end
	end

endmodule

>>> tb/mdio_phy_register_model_unit_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for mdio_phy_register_model_unit: directed and random
// bus, PHY and link items checked against an in-bench register model.
// Depends on mprm_pkg, mprm_if and the RTL of the unit.
module mdio_phy_register_model_unit_tb;
	import mprm_pkg::*;

	localparam logic [1:0] FUNC_NONE = 2'd3;
	localparam int WATCHDOG_LIMIT = 2000;

	typedef enum {READY_ALWAYS, READY_PATTERN, READY_SPARSE} ready_mode_t;

	logic clk;
	logic arst_n;

	mprm_req_if req();
	mprm_rsp_if rsp();

	mdio_phy_register_model_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	// register model
	logic [31:0] m_cmd;
	logic [31:0] m_data;
	logic [15:0] m_ctrl;
	logic [15:0] m_status;
	logic [15:0] m_advert;
	logic [7:0]  m_irq_src;
	logic [7:0]  m_irq_en;
	logic        m_link_lost;

	logic [31:0] read_data_due[$];
	logic [31:0] due_value;

	int fail_count;
	int items_sent;
	int results_checked;
	int soft_resets;
	int link_events;
	int idle_cycles;
	int burst_left;
	bit gaps_on;
	ready_mode_t ready_mode;
	logic [31:0] stall_pattern;
	int pat_pos;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function void apply_link_state();
		if (m_link_lost) begin
			m_status &= ~STATUS_LINK;
			m_irq_src |= IRQ_LINK_LOST;
		end else begin
			m_status |= STATUS_LINK;
			m_irq_src |= IRQ_LINK_UP;
		end
	endfunction

	function void phy_restart();
		m_status = STATUS_SRST;
		m_ctrl = CONTROL_RST;
		m_advert = ADVERT_RST;
		m_irq_en = '0;
		m_irq_src = '0;
		apply_link_state();
	endfunction

	function logic [15:0] phy_fetch(input logic [4:0] regnum);
		logic [15:0] v;
		v = '0;
		case (regnum)
			PHY_BMCR:    v = m_ctrl;
			PHY_BMSR:    v = m_status;
			PHY_ID1:     v = ID1_VALUE;
			PHY_ID2:     v = ID2_VALUE;
			PHY_ADVERT:  v = m_advert;
			PHY_LPA:     v = LPA_VALUE;
			PHY_EXPAN:   v = EXPAN_VALUE;
			PHY_IRQ_SRC: begin
				v = {8'h00, m_irq_src};
				m_irq_src = '0;
			end
			PHY_IRQ_EN:  v = {8'h00, m_irq_en};
			default:     v = '0;
		endcase
		return v;
	endfunction

	function void phy_store(input logic [4:0] regnum, input logic [15:0] v);
		case (regnum)
			PHY_BMCR: begin
				if (v[CTRL_RESET_BIT]) begin
					phy_restart();
					soft_resets++;
				end else begin
					m_ctrl = v & CONTROL_MASK;
					if (v[CTRL_ANEG_BIT])
						m_status |= STATUS_ANEG;
				end
			end
			PHY_ADVERT: m_advert = (v & ADVERT_MASK) | ADVERT_FORCE;
			PHY_IRQ_EN: m_irq_en = v[7:0];
			default: ;
		endcase
	endfunction

	function logic [31:0] predict_read_data(input logic [1:0] f, input logic [7:0] off,
			input logic [31:0] wd, input logic down);
		logic [31:0] rd;
		logic [4:0]  regnum;
		rd = '0;
		if (f == FUNC_READ) begin
			if (off == OFF_CTRL)
				rd = m_cmd;
			else if (off == OFF_DATA)
				rd = m_data;
		end else if (f == FUNC_WRITE) begin
			if (off == OFF_CTRL) begin
				regnum = wd[CMD_REG_LO +: 5];
				m_cmd = wd;
				if (wd[CMD_WRITE_BIT]) begin
					phy_store(regnum, m_data[15:0]);
					m_cmd[CMD_WRITE_BIT] = 1'b0;
				end else begin
					m_data = {phy_fetch(regnum), 16'h0000};
					m_cmd[CMD_READ_BIT] = 1'b0;
				end
			end else if (off == OFF_DATA) begin
				m_data = wd;
			end
		end else if (f == FUNC_LINK) begin
			m_link_lost = down;
			apply_link_state();
			link_events++;
		end
		return rd;
	endfunction

	function logic [31:0] phy_cmd(input logic wr, input logic [4:0] regnum,
			input logic [31:0] noise);
		logic [31:0] c;
		c = noise;
		c[CMD_REG_LO +: 5] = regnum;
		c[CMD_WRITE_BIT] = wr;
		return c;
	endfunction

	function logic [4:0] pick_phy_reg();
		logic [4:0] r;
		case ($urandom_range(0, 11))
			0: r = PHY_BMCR;
			1: r = PHY_BMSR;
			2: r = PHY_ID1;
			3: r = PHY_ID2;
			4: r = PHY_ADVERT;
			5: r = PHY_LPA;
			6: r = PHY_EXPAN;
			7: r = PHY_IRQ_SRC;
			8: r = PHY_IRQ_EN;
			default: r = 5'($urandom_range(0, 31));
		endcase
		return r;
	endfunction

	// called and returns at a falling edge
	task send_item(input logic [1:0] f, input logic [7:0] off, input logic [31:0] wd,
			input logic down);
		req.valid <= 1'b1;
		req.func <= func_t'(f);
		req.bus_offset <= off;
		req.write_data <= wd;
		req.link_is_down <= down;
		@(posedge clk);
		while (!req.ready)
			@(posedge clk);
		read_data_due.push_back(predict_read_data(f, off, wd, down));
		items_sent++;
		@(negedge clk);
		if (gaps_on) begin
			if (burst_left == 0) begin
				req.valid <= 1'b0;
				repeat ($urandom_range(1, 12)) @(negedge clk);
				burst_left = $urandom_range(0, 20);
			end else begin
				burst_left--;
			end
		end
	endtask

	task wait_for_drain();
		req.valid <= 1'b0;
		while (read_data_due.size() != 0)
			@(negedge clk);
	endtask

	always @(negedge clk) begin
		case (ready_mode)
			READY_ALWAYS: rsp.ready <= 1'b1;
			READY_PATTERN: begin
				rsp.ready <= stall_pattern[pat_pos];
				if (pat_pos == 31) begin
					pat_pos <= 0;
					stall_pattern <= $urandom() | 32'h1;
				end else begin
					pat_pos <= pat_pos + 1;
				end
			end
			default: rsp.ready <= ($urandom_range(0, 3) == 0);
		endcase
	end

	always @(posedge clk) begin
		if (arst_n && rsp.valid && rsp.ready) begin
			if (read_data_due.size() == 0) begin
				$error("unexpected result: read_data=%h", rsp.read_data);
				fail_count++;
			end else begin
				due_value = read_data_due.pop_front();
				if (rsp.read_data !== due_value) begin
					$error("read_data mismatch: expected %h, actual %h", due_value,
						rsp.read_data);
					fail_count++;
				end
				results_checked++;
			end
		end
	end

	always @(posedge clk) begin
		if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: no item moved for %0d cycles", idle_cycles);
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	task test_reset_values();
		send_item(FUNC_READ, OFF_CTRL, $urandom(), 1'b1);
		send_item(FUNC_READ, OFF_DATA, 32'h0, 1'b0);
	endtask

	task test_phy_reads();
		send_item(FUNC_WRITE, OFF_CTRL, phy_cmd(1'b0, PHY_BMSR, 32'h0400_0000), 1'b0);
		send_item(FUNC_READ, OFF_CTRL, 32'h0, 1'b0);
		send_item(FUNC_READ, OFF_DATA, 32'h0, 1'b0);
	endtask

	task test_phy_writes();
		send_item(FUNC_WRITE, OFF_DATA, 32'h0000_7fff, 1'b0);
		send_item(FUNC_WRITE, OFF_CTRL, phy_cmd(1'b1, PHY_BMCR, 32'h0), 1'b0);
		send_item(FUNC_WRITE, OFF_DATA, 32'hffff_ffff, 1'b1);
		send_item(FUNC_WRITE, OFF_CTRL, phy_cmd(1'b1, PHY_ADVERT, 32'hffff_ffff), 1'b0);
		send_item(FUNC_WRITE, OFF_CTRL, phy_cmd(1'b1, PHY_IRQ_EN, 32'h0), 1'b0);
	endtask

	task test_link_and_irq();
		send_item(FUNC_LINK, OFF_CTRL, 32'hffff_ffff, 1'b1);
		// command with neither read nor write bit set
		send_item(FUNC_WRITE, OFF_CTRL, phy_cmd(1'b0, PHY_IRQ_SRC, 32'h0), 1'b0);
		send_item(FUNC_READ, OFF_DATA, 32'h0, 1'b0);
		send_item(FUNC_WRITE, OFF_CTRL, phy_cmd(1'b0, PHY_IRQ_SRC, 32'hf400_0000), 1'b0);
		send_item(FUNC_READ, OFF_CTRL, 32'h0, 1'b0);
		send_item(FUNC_LINK, 8'hff, $urandom(), 1'b0);
	endtask

	task test_soft_reset();
		send_item(FUNC_WRITE, OFF_CTRL, phy_cmd(1'b1, PHY_BMCR, 32'h0), 1'b0);
		send_item(FUNC_WRITE, OFF_CTRL, phy_cmd(1'b0, PHY_ID2, 32'h0400_0000), 1'b0);
		send_item(FUNC_READ, OFF_DATA, 32'h0, 1'b0);
	endtask

	task test_unmapped_access();
		send_item(FUNC_WRITE, OFF_CTRL, phy_cmd(1'b0, 5'd31, 32'h0400_0000), 1'b0);
		send_item(FUNC_READ, OFF_DATA, 32'h0, 1'b0);
		send_item(FUNC_NONE, OFF_CTRL, 32'hffff_ffff, 1'b1);
		send_item(FUNC_READ, 8'hff, 32'h0, 1'b0);
		send_item(FUNC_WRITE, 8'h00, 32'hffff_ffff, 1'b1);
		send_item(FUNC_READ, 8'h61, 32'h0, 1'b0);
	endtask

	task send_random_sequence();
		logic [4:0] regnum;
		int kind;
		kind = $urandom_range(0, 15);
		regnum = pick_phy_reg();
		if (kind < 6) begin
			send_item(FUNC_WRITE, OFF_DATA, $urandom(), 1'($urandom_range(0, 1)));
			send_item(FUNC_WRITE, OFF_CTRL, phy_cmd(1'b1, regnum, $urandom()), 1'b0);
			if ($urandom_range(0, 1)) begin
				send_item(FUNC_WRITE, OFF_CTRL, phy_cmd(1'b0, regnum, $urandom()), 1'b0);
				send_item(FUNC_READ, OFF_DATA, $urandom(), 1'b0);
			end
		end else if (kind < 10) begin
			send_item(FUNC_WRITE, OFF_CTRL, phy_cmd(1'b0, regnum, $urandom()), 1'b0);
			send_item(FUNC_READ, OFF_DATA, $urandom(), 1'($urandom_range(0, 1)));
			if ($urandom_range(0, 2) == 0)
				send_item(FUNC_READ, OFF_CTRL, $urandom(), 1'b0);
		end else if (kind < 12) begin
			send_item(FUNC_LINK, 8'($urandom_range(0, 255)), $urandom(),
				1'($urandom_range(0, 1)));
		end else if (kind < 14) begin
			send_item(2'($urandom_range(0, 1)), $urandom_range(0, 1) ? OFF_CTRL : OFF_DATA,
				$urandom(), 1'($urandom_range(0, 1)));
		end else begin
			send_item(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)), $urandom(),
				1'($urandom_range(0, 1)));
		end
	endtask

	task random_phase(input int count, input bit gaps, input ready_mode_t mode);
		int stop_at;
		stop_at = items_sent + count;
		gaps_on = gaps;
		ready_mode = mode;
		while (items_sent < stop_at)
			send_random_sequence();
	endtask

	task test_random_traffic();
		random_phase(350, 1'b1, READY_PATTERN);
		// hold the sender until the unit is empty
		wait_for_drain();
		random_phase(350, 1'b0, READY_ALWAYS);
		random_phase(350, 1'b1, READY_SPARSE);
		wait_for_drain();
		random_phase(350, 1'b0, READY_PATTERN);
	endtask

	task finish_run();
		wait_for_drain();
		repeat (4) @(posedge clk);
		$display("covered %0d items, %0d results checked, %0d PHY soft resets, %0d link events",
			items_sent, results_checked, soft_resets, link_events);
		if (fail_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	endtask

	initial begin
		arst_n = 1'b0;
		req.valid = 1'b0;
		req.func = FUNC_READ;
		req.bus_offset = '0;
		req.write_data = '0;
		req.link_is_down = 1'b0;
		rsp.ready = 1'b0;
		fail_count = 0;
		items_sent = 0;
		results_checked = 0;
		soft_resets = 0;
		link_events = 0;
		idle_cycles = 0;
		burst_left = 0;
		gaps_on = 1'b1;
		ready_mode = READY_PATTERN;
		stall_pattern = $urandom() | 32'h1;
		pat_pos = 0;
		m_cmd = '0;
		m_data = '0;
		m_link_lost = 1'b0;
		phy_restart();
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_reset_values();
		test_phy_reads();
		test_phy_writes();
		test_link_and_irq();
		test_soft_reset();
		test_unmapped_access();
		test_random_traffic();
		finish_run();
	end

endmodule

>>> files.f
rtl/mprm_pkg.sv
rtl/mprm_if.sv
rtl/mprm_phy.sv
rtl/mprm_bus.sv
rtl/mdio_phy_register_model_unit.sv
tb/mdio_phy_register_model_unit_tb.sv
